### rtl/core/mbcs_pkg.sv
package mbcs_pkg;

	localparam int unsigned TIME_WIDTH_DEF = 64;
	localparam int unsigned NOW_WIDTH      = 64;
	localparam int unsigned CFG_WIDTH      = 32;
	localparam int unsigned CFG_IDX_WIDTH  = 8;
	localparam int unsigned BURST_WIDTH    = 32;
	localparam int unsigned FRAME_WIDTH    = 16;
	localparam int unsigned IN_DATA_WIDTH  = 64;
	localparam int unsigned IN_USER_WIDTH  = 1;
	localparam int unsigned OUT_DATA_WIDTH = 48;
	localparam int unsigned OUT_USER_WIDTH = 4;

	localparam logic [CFG_WIDTH-1:0] BURST_DURATION_RST     = 32'd2000;
	localparam logic [CFG_WIDTH-1:0] BURST_INTERVAL_RST     = 32'd250;
	localparam logic [CFG_WIDTH-1:0] ACTIVE_INTERVAL_RST    = 32'd5000;
	localparam logic [CFG_WIDTH-1:0] INACTIVITY_TIMEOUT_RST = 32'd30000;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_BURST_DURATION     = 8'd0,
		REG_BURST_INTERVAL     = 8'd1,
		REG_ACTIVE_INTERVAL    = 8'd2,
		REG_INACTIVITY_TIMEOUT = 8'd3
	} reg_index_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] burst_duration;
		logic [CFG_WIDTH-1:0] burst_interval;
		logic [CFG_WIDTH-1:0] active_interval;
		logic [CFG_WIDTH-1:0] inactivity_timeout;
	} cfg_t;

	typedef struct packed {
		logic                   capture;
		logic                   is_burst_frame;
		logic [BURST_WIDTH-1:0] burst_id;
		logic [FRAME_WIDTH-1:0] frame_in_burst;
		logic                   activity_is_open;
		logic                   order_error;
	} res_t;

endpackage

### rtl/core/mbcs_cfg.sv
module mbcs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mbcs_pkg::CFG_IDX_WIDTH-1:0]  wr_index,
	input  logic [mbcs_pkg::CFG_WIDTH-1:0]      wr_data,
	output mbcs_pkg::cfg_t                      cfg
);
	import mbcs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_duration     <= BURST_DURATION_RST;
			cfg_q.burst_interval     <= BURST_INTERVAL_RST;
			cfg_q.active_interval    <= ACTIVE_INTERVAL_RST;
			cfg_q.inactivity_timeout <= INACTIVITY_TIMEOUT_RST;
		end else if (wr_en) begin
			// drop writes to indexes beyond the register list
			unique case (reg_index_t'(wr_index))
				REG_BURST_DURATION:     cfg_q.burst_duration     <= wr_data;
				REG_BURST_INTERVAL:     cfg_q.burst_interval     <= wr_data;
				REG_ACTIVE_INTERVAL:    cfg_q.active_interval    <= wr_data;
				REG_INACTIVITY_TIMEOUT: cfg_q.inactivity_timeout <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/mbcs_core.sv
module mbcs_core #(
	parameter int unsigned TIME_WIDTH = mbcs_pkg::TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [TIME_WIDTH-1:0] t,
	input  logic                  motion,
	input  mbcs_pkg::cfg_t        cfg,
	output mbcs_pkg::res_t        res
);
	import mbcs_pkg::*;

	function automatic logic [TIME_WIDTH-1:0] sat_add(input logic [TIME_WIDTH-1:0] a,
	                                                   input logic [CFG_WIDTH-1:0] b);
		logic [TIME_WIDTH:0] sum;
		sum = {1'b0, a} + {{(TIME_WIDTH + 1 - CFG_WIDTH){1'b0}}, b};
		return sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];
	endfunction

	logic                   seen_q,  seen_d;
	logic [TIME_WIDTH-1:0]  last_seen_q, last_seen_d;
	logic                   act_q,   act_d;
	logic [TIME_WIDTH-1:0]  last_motion_q, last_motion_d;
	logic [BURST_WIDTH-1:0] burst_cnt_q, burst_cnt_d;
	logic [FRAME_WIDTH-1:0] frame_cnt_q, frame_cnt_d;
	logic [TIME_WIDTH-1:0]  burst_end_q, burst_end_d;
	logic [TIME_WIDTH-1:0]  next_burst_q, next_burst_d;
	logic [TIME_WIDTH-1:0]  next_active_q, next_active_d;

	logic [TIME_WIDTH-1:0]  t_plus_dur, t_plus_bint, t_plus_aint, end_plus_aint, quiet_limit;
	logic [TIME_WIDTH-1:0]  burst_end_e, next_active_e;
	logic [FRAME_WIDTH-1:0] frame_inc;
	logic                   order_err, new_burst;

	assign t_plus_dur    = sat_add(t, cfg.burst_duration);
	assign t_plus_bint   = sat_add(t, cfg.burst_interval);
	assign t_plus_aint   = sat_add(t, cfg.active_interval);
	assign end_plus_aint = sat_add(t_plus_dur, cfg.active_interval);
	assign quiet_limit   = sat_add(last_motion_q, cfg.inactivity_timeout);
	assign frame_inc     = (frame_cnt_q != {FRAME_WIDTH{1'b1}}) ? frame_cnt_q + 1'b1 : frame_cnt_q;

	assign order_err     = seen_q && (t < last_seen_q);
	assign new_burst     = motion && (!act_q || (t > burst_end_q));
	// motion inside the window pushes its end out
	assign burst_end_e   = motion ? t_plus_dur    : burst_end_q;
	assign next_active_e = motion ? end_plus_aint : next_active_q;

	always_comb begin
		seen_d        = seen_q;
		last_seen_d   = last_seen_q;
		act_d         = act_q;
		last_motion_d = last_motion_q;
		burst_cnt_d   = burst_cnt_q;
		frame_cnt_d   = frame_cnt_q;
		burst_end_d   = burst_end_q;
		next_burst_d  = next_burst_q;
		next_active_d = next_active_q;
		res           = '0;

		if (order_err) begin
			res.order_error = 1'b1;
		end else begin
			seen_d      = 1'b1;
			last_seen_d = t;
			if (motion) begin
				last_motion_d = t;
			end
			if (new_burst) begin
				act_d              = 1'b1;
				burst_cnt_d        = burst_cnt_q + 1'b1;
				frame_cnt_d        = {{(FRAME_WIDTH-1){1'b0}}, 1'b1};
				burst_end_d        = t_plus_dur;
				next_burst_d       = t_plus_bint;
				next_active_d      = end_plus_aint;
				res.capture        = 1'b1;
				res.is_burst_frame = 1'b1;
				res.burst_id       = burst_cnt_q + 1'b1;
			end else begin
				burst_end_d   = burst_end_e;
				next_active_d = next_active_e;
				if (act_q) begin
					if (!motion && (t >= quiet_limit)) begin
						act_d = 1'b0;
					end else if ((t <= burst_end_e) && (t >= next_burst_q)) begin
						next_burst_d       = t_plus_bint;
						frame_cnt_d        = frame_inc;
						res.capture        = 1'b1;
						res.is_burst_frame = 1'b1;
						res.burst_id       = burst_cnt_q;
						res.frame_in_burst = frame_cnt_q;
					end else if ((t > burst_end_e) && (t >= next_active_e)) begin
						next_active_d = t_plus_aint;
						res.capture   = 1'b1;
						res.burst_id  = burst_cnt_q;
					end
				end
			end
		end
		res.activity_is_open = act_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			last_seen_q   <= '0;
			act_q         <= 1'b0;
			last_motion_q <= '0;
			burst_cnt_q   <= '0;
			frame_cnt_q   <= '0;
			burst_end_q   <= '0;
			next_burst_q  <= '0;
			next_active_q <= '0;
		end else if (step) begin
			seen_q        <= seen_d;
			last_seen_q   <= last_seen_d;
			act_q         <= act_d;
			last_motion_q <= last_motion_d;
			burst_cnt_q   <= burst_cnt_d;
			frame_cnt_q   <= frame_cnt_d;
			burst_end_q   <= burst_end_d;
			next_burst_q  <= next_burst_d;
			next_active_q <= next_active_d;
		end
	end

endmodule

### rtl/core/motion_burst_capture_scheduler_unit.sv
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid/s_tready    tdata now_ms, tuser detected
// m_*      out        m_tvalid/m_tready    tdata burst_id, frame_in_burst; tuser flags
// cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One observation per cycle sustained while the output is not stalled; a result is offered once it
// has passed the input register, then one pass through the scheduler logic into the result register.
// The scheduler state updates in the cycle the observation moves into the result register.
// Reset is asynchronous: state clears, registers return to their defaults, no warm-up pass.
// A stalled output holds the result register and the input register behind it; input
// is still taken while the input register is empty or draining.
module motion_burst_capture_scheduler_unit #(
	parameter int unsigned TIME_WIDTH = mbcs_pkg::TIME_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mbcs_pkg::IN_DATA_WIDTH-1:0]   s_tdata,  // [63:0] now_ms
	input  logic [mbcs_pkg::IN_USER_WIDTH-1:0]   s_tuser,  // [0] detected
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mbcs_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,  // [31:0] burst_id, [47:32] frame_in_burst
	output logic [mbcs_pkg::OUT_USER_WIDTH-1:0]  m_tuser,  // [0] capture, [1] is_burst_frame,
	                                                       // [2] activity_is_open, [3] order_error
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbcs_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [mbcs_pkg::CFG_WIDTH-1:0]       cfg_data
);
	import mbcs_pkg::*;

	cfg_t                  cfg;
	res_t                  res, res_s2;
	logic                  valid_s1, valid_s2;
	logic [TIME_WIDTH-1:0] time_s1;
	logic                  motion_s1;
	logic                  adv_s1;

	assign cfg_ready = 1'b1;

	mbcs_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			time_s1   <= s_tdata[TIME_WIDTH-1:0];
			motion_s1 <= s_tuser[0];
		end
	end

	mbcs_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.t      (time_s1),
		.motion (motion_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.frame_in_burst, res_s2.burst_id};
	assign m_tuser  = {res_s2.order_error, res_s2.activity_is_open,
	                   res_s2.is_burst_frame, res_s2.capture};

`ifndef ASSERT_OFF
	a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
		else $error("input taken while both stages are stalled");

	a_transfer_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted observation lost before the input register");

	a_capture_needs_activity: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.capture) |-> res_s2.activity_is_open)
		else $error("capture reported with activity closed");

	a_reject_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.order_error) |-> (!res_s2.capture && res_s2.burst_id == '0))
		else $error("rejected observation produced a capture");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("scheduler step without a result");
`endif

endmodule

### test/tb_motion_burst_capture_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_motion_burst_capture_scheduler_unit;
	import mbcs_pkg::*;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED = 8'd9;
	localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] CFG_MAX = 32'hFFFF_FFFF;
	localparam int unsigned STEP_CAP = 1000000;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_DATA_WIDTH-1:0]  s_tdata;   // [63:0] now_ms
	logic [IN_USER_WIDTH-1:0]  s_tuser;   // [0] detected
	logic                      m_tvalid;
	logic                      m_tready;
	logic [OUT_DATA_WIDTH-1:0] m_tdata;   // [31:0] burst_id, [47:32] frame_in_burst
	logic [OUT_USER_WIDTH-1:0] m_tuser;   // [0] capture, [1] is_burst_frame,
	                                      // [2] activity_is_open, [3] order_error
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [CFG_WIDTH-1:0]      cfg_data;

	motion_burst_capture_scheduler_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// scheduler configuration and state as the predictor sees it
	logic [31:0] cfg_burst_len;
	logic [31:0] cfg_burst_gap;
	logic [31:0] cfg_active_gap;
	logic [31:0] cfg_quiet_limit;

	logic        sch_seen;
	logic [63:0] sch_last_seen;
	logic        sch_active;
	logic [63:0] sch_last_motion;
	logic [31:0] sch_burst_no;
	logic [15:0] sch_frame_no;
	logic [63:0] sch_burst_end;
	logic [63:0] sch_next_burst;
	logic [63:0] sch_next_active;

	res_t        pending_captures[$];
	int unsigned fail_count;
	logic [63:0] obs_time;
	bit          idle_tx;
	bit          idle_rx;
	int unsigned rx_hold_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [63:0] time_add(logic [63:0] a, logic [63:0] b);
		logic [64:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[64] ? TIME_MAX : sum[63:0];
	endfunction

	function automatic res_t take_burst_frame();
		res_t r;
		r = '0;
		r.capture        = 1'b1;
		r.is_burst_frame = 1'b1;
		r.burst_id       = sch_burst_no;
		r.frame_in_burst = sch_frame_no;
		if (sch_frame_no != 16'hFFFF)
			sch_frame_no = sch_frame_no + 16'd1;
		return r;
	endfunction

	function automatic res_t schedule_capture(logic [63:0] t, logic motion);
		res_t r;
		r = '0;
		// backwards timestamp: reject, keep state
		if (sch_seen && t < sch_last_seen) begin
			r.activity_is_open = sch_active;
			r.order_error      = 1'b1;
			return r;
		end
		sch_seen      = 1'b1;
		sch_last_seen = t;
		if (motion) begin
			sch_last_motion = t;
			if (!sch_active || t > sch_burst_end) begin
				sch_active      = 1'b1;
				sch_burst_no    = sch_burst_no + 32'd1;
				sch_frame_no    = '0;
				sch_burst_end   = time_add(t, 64'(cfg_burst_len));
				sch_next_burst  = time_add(t, 64'(cfg_burst_gap));
				sch_next_active = time_add(sch_burst_end, 64'(cfg_active_gap));
				r = take_burst_frame();
				r.activity_is_open = 1'b1;
				return r;
			end
			// motion inside the window stretches it
			sch_burst_end   = time_add(t, 64'(cfg_burst_len));
			sch_next_active = time_add(sch_burst_end, 64'(cfg_active_gap));
		end
		if (sch_active) begin
			if (!motion && t >= time_add(sch_last_motion, 64'(cfg_quiet_limit))) begin
				sch_active = 1'b0;
			end else if (t <= sch_burst_end && t >= sch_next_burst) begin
				sch_next_burst = time_add(t, 64'(cfg_burst_gap));
				r = take_burst_frame();
			end else if (t > sch_burst_end && t >= sch_next_active) begin
				sch_next_active = time_add(t, 64'(cfg_active_gap));
				r.capture  = 1'b1;
				r.burst_id = sch_burst_no;
			end
		end
		r.activity_is_open = sch_active;
		return r;
	endfunction

	function automatic int unsigned step_span(logic [63:0] span);
		return (span > 64'(STEP_CAP)) ? STEP_CAP : int'(span[31:0]);
	endfunction

	task automatic send_obs(logic [63:0] t, logic motion);
		int unsigned gap;
		gap = idle_tx ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		s_tuser  <= motion;
		do @(posedge clk); while (!s_tready);
		pending_captures.push_back(schedule_capture(t, motion));
	endtask

	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_captures.size() != 0 && waited < 3000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_captures.size() != 0) begin
			fail_count++;
			$error("%0d expected results never arrived", pending_captures.size());
			pending_captures.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// write all four registers back to back, then poke an unmapped index
	task automatic write_config(logic [31:0] burst_len, logic [31:0] burst_gap,
	                            logic [31:0] active_gap, logic [31:0] quiet_limit);
		logic [CFG_IDX_WIDTH-1:0] idx [5];
		logic [CFG_WIDTH-1:0]     val [5];
		idx[0] = REG_BURST_DURATION;     val[0] = burst_len;
		idx[1] = REG_BURST_INTERVAL;     val[1] = burst_gap;
		idx[2] = REG_ACTIVE_INTERVAL;    val[2] = active_gap;
		idx[3] = REG_INACTIVITY_TIMEOUT; val[3] = quiet_limit;
		idx[4] = REG_UNMAPPED;           val[4] = $urandom;
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_BURST_DURATION:     cfg_burst_len   = val[i];
				REG_BURST_INTERVAL:     cfg_burst_gap   = val[i];
				REG_ACTIVE_INTERVAL:    cfg_active_gap  = val[i];
				REG_INACTIVITY_TIMEOUT: cfg_quiet_limit = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_default_schedule();
		send_obs(64'd0, 1'b0);
		send_obs(64'd100, 1'b1);
		send_obs(64'd100, 1'b0);
		send_obs(64'd350, 1'b0);
		send_obs(64'd1000, 1'b1);
		send_obs(64'd3000, 1'b0);
		send_obs(64'd3001, 1'b0);
		send_obs(64'd8000, 1'b0);
		send_obs(64'd13000, 1'b0);
		send_obs(64'd31000, 1'b0);
		send_obs(64'd31000, 1'b0);
		send_obs(64'd31500, 1'b1);
		send_obs(64'd40000, 1'b1);
		obs_time = 64'd40000;
	endtask

	task automatic test_order_error();
		send_obs(64'd39999, 1'b1);
		send_obs(64'd40000, 1'b0);
		send_obs(64'd80000, 1'b0);
		send_obs(64'd0, 1'b0);
		obs_time = 64'd80000;
	endtask

	task automatic test_saturating_sums();
		drain_results();
		write_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
		// leave headroom below the top for the rest of the run
		obs_time = 64'hFFFF_FFFF_7FFF_FFFF;
		send_obs(obs_time, 1'b1);
		send_obs(obs_time + 64'd1, 1'b0);
		send_obs(obs_time + 64'd2, 1'b1);
		drain_results();
		write_config(32'd1, 32'd1, 32'd1, 32'd2);
		send_obs(obs_time + 64'd10, 1'b0);
		send_obs(obs_time + 64'd11, 1'b1);
		send_obs(obs_time + 64'd12, 1'b0);
		send_obs(obs_time + 64'd13, 1'b0);
		send_obs(obs_time + 64'd13, 1'b1);
		obs_time = obs_time + 64'd13;
	endtask

	task automatic test_frame_counter_run();
		drain_results();
		write_config(CFG_MAX, 32'd1, 32'd1, CFG_MAX);
		idle_tx = 1'b0;
		idle_rx = 1'b0;
		obs_time = obs_time + 64'd1;
		send_obs(obs_time, 1'b1);
		for (int i = 0; i < 40; i++) begin
			obs_time = obs_time + 64'd1;
			send_obs(obs_time, 1'b0);
		end
		idle_tx = 1'b1;
		idle_rx = 1'b1;
	endtask

	task automatic test_output_backpressure();
		drain_results();
		write_config(32'd30, 32'd2, 32'd7, 32'd90);
		idle_tx = 1'b0;
		rx_hold_cycles = 120;
		for (int i = 0; i < 48; i++) begin
			obs_time = obs_time + 64'($urandom_range(0, 5));
			send_obs(obs_time, $urandom_range(0, 99) < 30);
		end
		idle_tx = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [63:0] t;
		int unsigned pick;
		int unsigned motion_pct;
		for (int phase = 0; phase < 7; phase++) begin
			drain_results();
			case (phase)
				0: write_config(32'd1, 32'd1, 32'd1, 32'd2);
				1: write_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
				2: write_config(BURST_DURATION_RST, BURST_INTERVAL_RST, ACTIVE_INTERVAL_RST,
				                INACTIVITY_TIMEOUT_RST);
				default: begin
					pick = $urandom_range(1, 60);
					write_config(pick, $urandom_range(1, 15), $urandom_range(1, 40),
					             pick + $urandom_range(1, 120));
				end
			endcase
			idle_tx    = $urandom_range(0, 3) != 0;
			idle_rx    = $urandom_range(0, 3) != 0;
			motion_pct = $urandom_range(5, 60);
			for (int i = 0; i < 133; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					t = obs_time - 64'($urandom_range(1, 5000));
				end else begin
					// mostly short hops, sometimes long enough to close the activity
					if (pick < 14)
						obs_time = obs_time + 64'($urandom_range(0, step_span(
						           64'(cfg_quiet_limit) + 64'(cfg_burst_len) + 64'(cfg_active_gap))));
					else
						obs_time = obs_time + 64'($urandom_range(0, step_span(
						           2 * 64'(cfg_burst_gap) + 64'd1)));
					t = obs_time;
				end
				send_obs(t, $urandom_range(0, 99) < motion_pct);
			end
		end
		idle_tx = 1'b1;
		idle_rx = 1'b1;
	endtask

	task automatic test_time_ceiling();
		drain_results();
		write_config(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
		send_obs(TIME_MAX, 1'b1);
		send_obs(TIME_MAX, 1'b0);
		send_obs(TIME_MAX - 64'd1, 1'b0);
		send_obs(TIME_MAX, 1'b1);
		obs_time = TIME_MAX;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_captures.size() == 0) begin
				fail_count++;
				$error("result transfer with nothing expected");
			end else begin
				want = pending_captures.pop_front();
				compare_field("capture", 32'(want.capture), 32'(m_tuser[0]));
				compare_field("is_burst_frame", 32'(want.is_burst_frame), 32'(m_tuser[1]));
				compare_field("burst_id", want.burst_id, m_tdata[31:0]);
				compare_field("frame_in_burst", 32'(want.frame_in_burst), 32'(m_tdata[47:32]));
				compare_field("activity_is_open", 32'(want.activity_is_open), 32'(m_tuser[2]));
				compare_field("order_error", 32'(want.order_error), 32'(m_tuser[3]));
			end
		end
	end

	initial begin : result_sink
		int unsigned stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// long hold-off so the block fills up and stalls its input
			if (rx_hold_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = idle_rx ? $urandom_range(0, 18) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BURST_DURATION;
		cfg_data  <= '0;
		cfg_burst_len   = BURST_DURATION_RST;
		cfg_burst_gap   = BURST_INTERVAL_RST;
		cfg_active_gap  = ACTIVE_INTERVAL_RST;
		cfg_quiet_limit = INACTIVITY_TIMEOUT_RST;
		sch_seen        = 1'b0;
		sch_last_seen   = '0;
		sch_active      = 1'b0;
		sch_last_motion = '0;
		sch_burst_no    = '0;
		sch_frame_no    = '0;
		sch_burst_end   = '0;
		sch_next_burst  = '0;
		sch_next_active = '0;
		fail_count      = 0;
		obs_time        = '0;
		idle_tx         = 1'b1;
		idle_rx         = 1'b1;
		rx_hold_cycles  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_schedule();
		test_order_error();
		test_saturating_sums();
		test_frame_counter_run();
		test_output_backpressure();
		test_random_traffic();
		test_time_ceiling();
		drain_results();

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
